@@ hdl/mve_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mve_pkg
// Shared types and constants for the MessagePack value encoder.
// ----------------------------------------------------------------------------
package mve_pkg;

    // operation codes
    localparam logic [3:0] OP_NIL   = 4'd0;
    localparam logic [3:0] OP_BOOL  = 4'd1;
    localparam logic [3:0] OP_INT   = 4'd2;
    localparam logic [3:0] OP_UINT  = 4'd3;
    localparam logic [3:0] OP_F32   = 4'd4;
    localparam logic [3:0] OP_F64   = 4'd5;
    localparam logic [3:0] OP_STR   = 4'd6;
    localparam logic [3:0] OP_BIN   = 4'd7;
    localparam logic [3:0] OP_ARRAY = 4'd8;
    localparam logic [3:0] OP_MAP   = 4'd9;
    localparam logic [3:0] OP_EXT   = 4'd10;
    localparam logic [3:0] OP_BYTE  = 4'd11;

    // format bytes
    localparam logic [7:0] MP_NIL      = 8'hC0;
    localparam logic [7:0] MP_FALSE    = 8'hC2;
    localparam logic [7:0] MP_TRUE     = 8'hC3;
    localparam logic [7:0] MP_BIN8     = 8'hC4;
    localparam logic [7:0] MP_BIN16    = 8'hC5;
    localparam logic [7:0] MP_BIN32    = 8'hC6;
    localparam logic [7:0] MP_EXT8     = 8'hC7;
    localparam logic [7:0] MP_EXT16    = 8'hC8;
    localparam logic [7:0] MP_EXT32    = 8'hC9;
    localparam logic [7:0] MP_FLOAT32  = 8'hCA;
    localparam logic [7:0] MP_FLOAT64  = 8'hCB;
    localparam logic [7:0] MP_UINT8    = 8'hCC;
    localparam logic [7:0] MP_UINT16   = 8'hCD;
    localparam logic [7:0] MP_UINT32   = 8'hCE;
    localparam logic [7:0] MP_UINT64   = 8'hCF;
    localparam logic [7:0] MP_INT8     = 8'hD0;
    localparam logic [7:0] MP_INT16    = 8'hD1;
    localparam logic [7:0] MP_INT32    = 8'hD2;
    localparam logic [7:0] MP_INT64    = 8'hD3;
    localparam logic [7:0] MP_STR8     = 8'hD9;
    localparam logic [7:0] MP_STR16    = 8'hDA;
    localparam logic [7:0] MP_STR32    = 8'hDB;
    localparam logic [7:0] MP_ARRAY16  = 8'hDC;
    localparam logic [7:0] MP_ARRAY32  = 8'hDD;
    localparam logic [7:0] MP_MAP16    = 8'hDE;
    localparam logic [7:0] MP_MAP32    = 8'hDF;
    localparam logic [3:0] MP_FIXMAP   = 4'h8;
    localparam logic [3:0] MP_FIXARRAY = 4'h9;
    localparam logic [2:0] MP_FIXSTR   = 3'b101;

    // longest encoding: format byte plus eight data bytes
    localparam int MAX_BYTES = 9;
    localparam int CNT_W     = 4;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [3:0]         op;
        logic [63:0]        value;
        logic [31:0]        length;
        logic signed [7:0]  ext_type;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // encoded bytes, first byte in the top lane
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [CNT_W-1:0]       count;
    } desc_t;

    typedef struct packed {
        logic             bursting;
        logic [CNT_W-1:0] remain;
    } back_status_t;

endpackage : mve_pkg
`default_nettype wire

@@ hdl/mve_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mve_front
// Accepts items, picks the MessagePack form and builds the byte descriptor.
// ----------------------------------------------------------------------------
module mve_front
    import mve_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           push_valid,
    input  wire logic      push_ready,
    output desc_t          push_desc
);

    logic  valid_reg, valid_next;
    desc_t desc_reg, desc_next;
    desc_t cls;

    function automatic desc_t enc_uint(input logic [63:0] v);
        desc_t d;
        if (v[63:7] == '0) begin
            d.bytes = {v[7:0], 64'b0};              d.count = 4'd1;
        end else if (v[63:8] == '0) begin
            d.bytes = {MP_UINT8, v[7:0], 56'b0};    d.count = 4'd2;
        end else if (v[63:16] == '0) begin
            d.bytes = {MP_UINT16, v[15:0], 48'b0};  d.count = 4'd3;
        end else if (v[63:32] == '0) begin
            d.bytes = {MP_UINT32, v[31:0], 32'b0};  d.count = 4'd5;
        end else begin
            d.bytes = {MP_UINT64, v};               d.count = 4'd9;
        end
        return d;
    endfunction

    function automatic desc_t enc_int(input logic [63:0] v);
        desc_t d;
        if (!v[63]) begin
            d = enc_uint(v);
        end else if (&v[63:5]) begin
            d.bytes = {v[7:0], 64'b0};              d.count = 4'd1;
        end else if (&v[63:7]) begin
            d.bytes = {MP_INT8, v[7:0], 56'b0};     d.count = 4'd2;
        end else if (&v[63:15]) begin
            d.bytes = {MP_INT16, v[15:0], 48'b0};   d.count = 4'd3;
        end else if (&v[63:31]) begin
            d.bytes = {MP_INT32, v[31:0], 32'b0};   d.count = 4'd5;
        end else begin
            d.bytes = {MP_INT64, v};                d.count = 4'd9;
        end
        return d;
    endfunction

    function automatic desc_t enc_len3(input logic [31:0] len, input logic [7:0] c8,
                                       input logic [7:0] c16, input logic [7:0] c32);
        desc_t d;
        if (len[31:8] == '0) begin
            d.bytes = {c8, len[7:0], 56'b0};        d.count = 4'd2;
        end else if (len[31:16] == '0) begin
            d.bytes = {c16, len[15:0], 48'b0};      d.count = 4'd3;
        end else begin
            d.bytes = {c32, len, 32'b0};            d.count = 4'd5;
        end
        return d;
    endfunction

    function automatic desc_t enc_count(input logic [31:0] len, input logic [3:0] fix,
                                        input logic [7:0] c16, input logic [7:0] c32);
        desc_t d;
        if (len[31:4] == '0) begin
            d.bytes = {fix, len[3:0], 64'b0};       d.count = 4'd1;
        end else if (len[31:16] == '0) begin
            d.bytes = {c16, len[15:0], 48'b0};      d.count = 4'd3;
        end else begin
            d.bytes = {c32, len, 32'b0};            d.count = 4'd5;
        end
        return d;
    endfunction

    function automatic desc_t enc_ext(input logic [31:0] len, input logic [7:0] et);
        desc_t d;
        if (len[31:8] == '0) begin
            d.bytes = {MP_EXT8, len[7:0], et, 48'b0};   d.count = 4'd3;
        end else if (len[31:16] == '0) begin
            d.bytes = {MP_EXT16, len[15:0], et, 40'b0}; d.count = 4'd4;
        end else begin
            d.bytes = {MP_EXT32, len, et, 24'b0};       d.count = 4'd6;
        end
        return d;
    endfunction

    always_comb begin
        cls.bytes = '0;
        cls.count = '0;
        unique case (s_item.op)
            OP_NIL: begin
                cls.bytes = {MP_NIL, 64'b0};
                cls.count = 4'd1;
            end
            OP_BOOL: begin
                cls.bytes = {(s_item.value[0] ? MP_TRUE : MP_FALSE), 64'b0};
                cls.count = 4'd1;
            end
            OP_INT:   cls = enc_int(s_item.value);
            OP_UINT:  cls = enc_uint(s_item.value);
            OP_F32: begin
                cls.bytes = {MP_FLOAT32, s_item.value[31:0], 32'b0};
                cls.count = 4'd5;
            end
            OP_F64: begin
                cls.bytes = {MP_FLOAT64, s_item.value};
                cls.count = 4'd9;
            end
            OP_STR: begin
                if (s_item.length[31:5] == '0) begin
                    cls.bytes = {MP_FIXSTR, s_item.length[4:0], 64'b0};
                    cls.count = 4'd1;
                end else begin
                    cls = enc_len3(s_item.length, MP_STR8, MP_STR16, MP_STR32);
                end
            end
            OP_BIN:   cls = enc_len3(s_item.length, MP_BIN8, MP_BIN16, MP_BIN32);
            OP_ARRAY: cls = enc_count(s_item.length, MP_FIXARRAY, MP_ARRAY16, MP_ARRAY32);
            OP_MAP:   cls = enc_count(s_item.length, MP_FIXMAP, MP_MAP16, MP_MAP32);
            OP_EXT:   cls = enc_ext(s_item.length, s_item.ext_type);
            OP_BYTE: begin
                cls.bytes = {s_item.value[7:0], 64'b0};
                cls.count = 4'd1;
            end
            default: begin
                // unused codes produce no bytes
                cls.bytes = '0;
                cls.count = '0;
            end
        endcase
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_desc  = desc_reg;

    always_comb begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (s_valid && s_ready) begin
            // items that encode to nothing are dropped here
            valid_next = (cls.count != '0);
            desc_next  = cls;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        desc_reg <= desc_next;
    end

endmodule : mve_front
`default_nettype wire

@@ hdl/mve_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mve_queue
// Short descriptor queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module mve_queue
    import mve_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire desc_t  push_desc,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output desc_t       pop_desc,
    output logic [QAW:0] fill
);

    desc_t          mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   fill_reg, fill_next;
    logic           do_push, do_pop;

    assign push_ready = (fill_reg != (QAW+1)'(QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_desc   = mem[rd_ptr_reg];
    assign fill       = fill_reg;

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule : mve_queue
`default_nettype wire

@@ hdl/mve_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mve_back
// Serializer: sends the bytes of each descriptor one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module mve_back
    import mve_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    input  wire desc_t  pop_desc,
    output logic        m_valid,
    input  wire logic   m_ready,
    output out_item_t   m_item,
    output back_status_t status
);

    localparam int WORD_W = 8*(MAX_BYTES-1);

    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              advance;

    assign advance   = !m_valid_reg || m_ready;
    assign pop_ready = advance && (remain_reg == '0);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        word_next    = word_reg;
        remain_next  = remain_reg;
        if (advance) begin
            m_valid_next = 1'b0;
            if (remain_reg != '0) begin
                m_valid_next         = 1'b1;
                m_item_next.out_byte = word_reg[WORD_W-1 -: 8];
                m_item_next.last     = (remain_reg == CNT_W'(1));
                word_next            = {word_reg[WORD_W-9:0], 8'b0};
                remain_next          = remain_reg - 1'b1;
            end else if (pop_valid) begin
                m_valid_next         = 1'b1;
                m_item_next.out_byte = pop_desc.bytes[8*MAX_BYTES-1 -: 8];
                m_item_next.last     = (pop_desc.count == CNT_W'(1));
                word_next            = pop_desc.bytes[WORD_W-1:0];
                remain_next          = pop_desc.count - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            remain_reg  <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            remain_reg  <= remain_next;
        end
        m_item_reg <= m_item_next;
        word_reg   <= word_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_item          = m_item_reg;
    assign status.bursting = (remain_reg != '0);
    assign status.remain   = remain_reg;

endmodule : mve_back
`default_nettype wire

@@ hdl/msgpack_value_encoder.sv @@
`default_nettype none
// path: an item is registered in the classifier, the queue and the serializer output
// throughput: one output byte per cycle unless m_ready stalls; an item of n bytes
//   (1 to 9) holds the serializer until sent, so 1-byte items flow at one per cycle
// a four-entry descriptor queue lets intake run ahead of long header bursts
// reset: aresetn synchronous active low, clears all valids and the queue
// ----------------------------------------------------------------------------
// msgpack_value_encoder
// MessagePack element encoder: classifier, descriptor queue and byte serializer.
// ----------------------------------------------------------------------------
module msgpack_value_encoder
    import mve_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic         push_valid, push_ready;
    desc_t        push_desc;
    logic         pop_valid, pop_ready;
    desc_t        pop_desc;
    logic [QAW:0] q_fill;
    back_status_t b_status;

    mve_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    mve_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc),
        .fill       (q_fill)
    );

    mve_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .status    (b_status)
    );

    // queue fill never goes past its depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fill <= (QAW+1)'(QDEPTH))
        else $error("descriptor queue overfilled");

    // bytes still pending in the serializer imply a byte on the output
    a_burst_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        b_status.bursting |-> m_valid)
        else $error("serializer burst without output byte");

    // a byte without last always has more bytes of the same item behind it
    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.last) |-> b_status.bursting)
        else $error("non-final byte with nothing left to send");

    // nothing is popped while a burst is still being sent
    a_no_pop_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        b_status.bursting |-> !pop_ready)
        else $error("descriptor popped during burst");

endmodule : msgpack_value_encoder
`default_nettype wire

@@ bench/msgpack_value_encoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgpack_value_encoder_checker
// Watches both channels of the encoder. For every accepted input item it
// works out the MessagePack bytes that the element encodes to. It then
// checks each emitted byte and its last flag, in order.
// ----------------------------------------------------------------------------
module msgpack_value_encoder_checker
    import mve_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_item,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_item,
    output int             bytes_pending,
    output int             mismatch_count
);

    out_item_t expected_bytes[$];
    int        errors = 0;
    int        bytes_seen = 0;

    assign mismatch_count = errors;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t byte %0d: %s", $time, bytes_seen, msg);
        errors++;
    endtask

    function automatic void push_byte(input logic [7:0] b);
        out_item_t ob;
        ob.out_byte = b;
        ob.last     = 1'b0;
        expected_bytes.push_back(ob);
    endfunction

    // low nbytes of v, most significant first
    function automatic void push_be(input logic [63:0] v, input int nbytes);
        for (int i = nbytes; i > 0; i--) begin
            push_byte(v[8*i-1 -: 8]);
        end
    endfunction

    function automatic void push_sized(input logic [7:0] code, input logic [63:0] v,
                                       input int nbytes);
        push_byte(code);
        push_be(v, nbytes);
    endfunction

    function automatic void push_len3(input logic [31:0] len, input logic [7:0] c8,
                                      input logic [7:0] c16, input logic [7:0] c32);
        if (len <= 32'd255) begin
            push_sized(c8, 64'(len), 1);
        end else if (len <= 32'd65535) begin
            push_sized(c16, 64'(len), 2);
        end else begin
            push_sized(c32, 64'(len), 4);
        end
    endfunction

    function automatic void push_count(input logic [31:0] cnt, input logic [3:0] fix,
                                       input logic [7:0] c16, input logic [7:0] c32);
        if (cnt <= 32'd15) begin
            push_byte({fix, cnt[3:0]});
        end else if (cnt <= 32'd65535) begin
            push_sized(c16, 64'(cnt), 2);
        end else begin
            push_sized(c32, 64'(cnt), 4);
        end
    endfunction

    function automatic void encode_uint(input logic [63:0] v);
        if (v <= 64'd127) begin
            push_byte(v[7:0]);
        end else if (v <= 64'd255) begin
            push_sized(MP_UINT8, v, 1);
        end else if (v <= 64'd65535) begin
            push_sized(MP_UINT16, v, 2);
        end else if (v <= 64'hFFFF_FFFF) begin
            push_sized(MP_UINT32, v, 4);
        end else begin
            push_sized(MP_UINT64, v, 8);
        end
    endfunction

    // two's complement; negative ranges compared as unsigned bit patterns
    function automatic void encode_int(input logic [63:0] v);
        if (!v[63]) begin
            encode_uint(v);
        end else if (v >= ~64'd31) begin
            push_byte(v[7:0]);
        end else if (v >= ~64'd127) begin
            push_sized(MP_INT8, v, 1);
        end else if (v >= ~64'd32767) begin
            push_sized(MP_INT16, v, 2);
        end else if (v >= ~64'd2147483647) begin
            push_sized(MP_INT32, v, 4);
        end else begin
            push_sized(MP_INT64, v, 8);
        end
    endfunction

    function automatic void encode_element(input in_item_t it);
        int        first;
        out_item_t tail;
        first = expected_bytes.size();
        case (it.op)
            OP_NIL:   push_byte(MP_NIL);
            OP_BOOL:  push_byte(it.value[0] ? MP_TRUE : MP_FALSE);
            OP_INT:   encode_int(it.value);
            OP_UINT:  encode_uint(it.value);
            OP_F32:   push_sized(MP_FLOAT32, it.value, 4);
            OP_F64:   push_sized(MP_FLOAT64, it.value, 8);
            OP_STR: begin
                if (it.length <= 32'd31) begin
                    push_byte({MP_FIXSTR, it.length[4:0]});
                end else begin
                    push_len3(it.length, MP_STR8, MP_STR16, MP_STR32);
                end
            end
            OP_BIN:   push_len3(it.length, MP_BIN8, MP_BIN16, MP_BIN32);
            OP_ARRAY: push_count(it.length, MP_FIXARRAY, MP_ARRAY16, MP_ARRAY32);
            OP_MAP:   push_count(it.length, MP_FIXMAP, MP_MAP16, MP_MAP32);
            OP_EXT: begin
                push_len3(it.length, MP_EXT8, MP_EXT16, MP_EXT32);
                push_byte(it.ext_type);
            end
            OP_BYTE:  push_byte(it.value[7:0]);
            default: ;
        endcase
        // flag the final byte of this element
        if (expected_bytes.size() > first) begin
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            expected_bytes.delete();
        end else begin
            // compare before predicting: a new item cannot emit in its own cycle
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              m_item.out_byte, m_item.last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_item.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_item.out_byte, want.out_byte));
                    end
                    if (m_item.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_item.last, want.last));
                    end
                end
                bytes_seen++;
            end
            if (s_valid && s_ready) begin
                encode_element(s_item);
            end
        end
        bytes_pending <= expected_bytes.size();
    end

endmodule

@@ bench/msgpack_value_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgpack_value_encoder_tb
// Drives the encoder with directed edge cases and then with random element
// sequences: headers with bodies, containers with scalars, and noise. Both
// sides idle at random and the receiver holds off once for a long stretch.
// A checker beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module msgpack_value_encoder_tb;
    import mve_pkg::*;

    // op codes the block ignores
    localparam logic [3:0] OP_SPARE_LO = 4'd12;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    localparam int N_ITEMS     = 360;
    localparam int QUIET_ITEMS = 40;
    localparam int HOLD_ITEMS  = 30;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int bytes_pending;
    int mismatch_count;
    int items_sent;
    bit idle_en;
    bit hold_req;

    msgpack_value_encoder u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    msgpack_value_encoder_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .bytes_pending  (bytes_pending),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic in_item_t make_item(input logic [3:0] op, input logic [63:0] value,
                                           input logic [31:0] length,
                                           input logic [7:0] etype);
        in_item_t it;
        it.op       = op;
        it.value    = value;
        it.length   = length;
        it.ext_type = etype;
        return it;
    endfunction

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    // mixes small values, random magnitudes of both signs and form boundaries
    function automatic logic [63:0] rand_value();
        logic [63:0] w;
        w = rand_wide();
        case ($urandom_range(5, 0))
            0: return 64'($urandom_range(300, 0));
            1: return w >> $urandom_range(63, 0);
            2: return ~(w >> $urandom_range(63, 0));
            3: begin
                case ($urandom_range(15, 0))
                    0:  return 64'd127;
                    1:  return 64'd128;
                    2:  return 64'd255;
                    3:  return 64'd256;
                    4:  return 64'd65535;
                    5:  return 64'd65536;
                    6:  return 64'hFFFF_FFFF;
                    7:  return 64'h1_0000_0000;
                    8:  return 64'hFFFF_FFFF_FFFF_FFE0;
                    9:  return 64'hFFFF_FFFF_FFFF_FFDF;
                    10: return 64'hFFFF_FFFF_FFFF_FF80;
                    11: return 64'hFFFF_FFFF_FFFF_FF7F;
                    12: return 64'hFFFF_FFFF_FFFF_8000;
                    13: return 64'hFFFF_FFFF_FFFF_7FFF;
                    14: return 64'hFFFF_FFFF_8000_0000;
                    default: return 64'hFFFF_FFFF_7FFF_FFFF;
                endcase
            end
            default: return w;
        endcase
    endfunction

    function automatic logic [31:0] rand_length();
        case ($urandom_range(3, 0))
            0: return $urandom_range(40, 0);
            1: return $urandom;
            default: begin
                case ($urandom_range(7, 0))
                    0: return 32'd15;
                    1: return 32'd16;
                    2: return 32'd31;
                    3: return 32'd32;
                    4: return 32'd255;
                    5: return 32'd256;
                    6: return 32'd65535;
                    default: return 32'd65536;
                endcase
            end
        endcase
    endfunction

    // valid is only lowered at the start of a gap, never between back-to-back items
    task automatic send_item(input in_item_t it);
        if (idle_en && $urandom_range(3, 0) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.op <= OP_BYTE) items_sent++;
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (bytes_pending != 0);
    endtask

    task automatic send_scalar();
        logic [3:0] op;
        case ($urandom_range(9, 0))
            0:       op = OP_NIL;
            1:       op = OP_BOOL;
            2:       op = OP_F32;
            3:       op = OP_F64;
            4, 5, 6: op = OP_INT;
            default: op = OP_UINT;
        endcase
        send_item(make_item(op, rand_value(), $urandom, 8'($urandom)));
    endtask

    task automatic send_group();
        int          kind;
        int          n;
        logic [3:0]  op;
        logic [31:0] len;
        kind = $urandom_range(19, 0);
        if (kind < 8) begin
            case ($urandom_range(2, 0))
                0:       op = OP_STR;
                1:       op = OP_BIN;
                default: op = OP_EXT;
            endcase
            len = ($urandom_range(5, 0) == 0) ? rand_length() : $urandom_range(12, 0);
            send_item(make_item(op, rand_wide(), len, 8'($urandom)));
            // large declared lengths get a short, truncated body
            n = (len > 12) ? $urandom_range(4, 0) : len;
            repeat (n) send_item(make_item(OP_BYTE, rand_wide(), $urandom, 8'($urandom)));
        end else if (kind < 11) begin
            op  = ($urandom_range(1, 0) == 0) ? OP_ARRAY : OP_MAP;
            len = ($urandom_range(3, 0) == 0) ? rand_length() : $urandom_range(6, 0);
            send_item(make_item(op, rand_wide(), len, 8'($urandom)));
            n = (len > 6) ? $urandom_range(3, 0) : len;
            repeat (n) send_scalar();
        end else if (kind < 17) begin
            send_scalar();
        end else if (kind < 19) begin
            send_item(make_item(4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), rand_wide(),
                                $urandom, 8'($urandom)));
        end else begin
            // stray body bytes with no header
            repeat ($urandom_range(4, 1))
                send_item(make_item(OP_BYTE, rand_wide(), $urandom, 8'($urandom)));
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_en && $urandom_range(5, 0) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("** msgpack_value_encoder: FAILED **");
        $finish;
    end

    initial begin
        int target;
        s_valid    <= 1'b0;
        s_item     <= '0;
        aresetn    <= 1'b0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // form boundaries and every op
        send_item(make_item(OP_NIL,   64'd0, 32'd0, 8'h00));
        send_item(make_item(OP_BOOL,  64'hFFFF_FFFF_FFFF_FFFE, 32'd0, 8'h00));
        send_item(make_item(OP_BOOL,  64'd1, 32'd0, 8'h00));
        send_item(make_item(OP_UINT,  64'd127, 32'd0, 8'h00));
        send_item(make_item(OP_UINT,  64'd255, 32'd0, 8'h00));
        send_item(make_item(OP_UINT,  64'd65535, 32'd0, 8'h00));
        send_item(make_item(OP_UINT,  64'hFFFF_FFFF, 32'd0, 8'h00));
        send_item(make_item(OP_UINT,  64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'hFFFF_FFFF_FFFF_FFE0, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'hFFFF_FFFF_FFFF_FFDF, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'hFFFF_FFFF_FFFF_FF80, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'hFFFF_FFFF_FFFF_8000, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'hFFFF_FFFF_8000_0000, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'h8000_0000_0000_0000, 32'd0, 8'h00));
        send_item(make_item(OP_INT,   64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 8'h00));
        // float32 ignores the upper half of value
        send_item(make_item(OP_F32,   64'hDEAD_BEEF_3F80_0000, 32'd0, 8'h00));
        send_item(make_item(OP_F64,   64'h4009_21FB_5444_2D18, 32'd0, 8'h00));
        send_item(make_item(OP_STR,   64'd0, 32'd31, 8'h00));
        send_item(make_item(OP_STR,   64'd0, 32'd32, 8'h00));
        send_item(make_item(OP_BIN,   64'd0, 32'd0, 8'h00));
        send_item(make_item(OP_ARRAY, 64'd0, 32'd15, 8'h00));
        send_item(make_item(OP_MAP,   64'd0, 32'd65536, 8'h00));
        send_item(make_item(OP_EXT,   64'd0, 32'd256, 8'h80));
        send_item(make_item(OP_EXT,   64'd0, 32'hFFFF_FFFF, 8'h7F));
        send_item(make_item(OP_BYTE,  64'h1234_5678_9ABC_DEAB, 32'hFFFF_FFFF, 8'hFF));
        send_item(make_item(OP_SPARE_LO, rand_wide(), $urandom, 8'($urandom)));
        send_item(make_item(OP_SPARE_HI, rand_wide(), $urandom, 8'($urandom)));
        pause_until_drained();

        while (items_sent < N_ITEMS / 3) send_group();

        // receiver holds off while items keep coming, so intake backs up
        hold_req = 1'b1;
        target   = items_sent + HOLD_ITEMS;
        while (items_sent < target) send_group();
        pause_until_drained();

        while (items_sent < N_ITEMS - QUIET_ITEMS) send_group();
        idle_en = 1'b0;
        while (items_sent < N_ITEMS) send_group();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && bytes_pending == 0) begin
            $display("** msgpack_value_encoder: PASSED **");
        end else begin
            $display("** msgpack_value_encoder: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mve_pkg.sv
hdl/mve_front.sv
hdl/mve_queue.sv
hdl/mve_back.sv
hdl/msgpack_value_encoder.sv
bench/msgpack_value_encoder_checker.sv
bench/msgpack_value_encoder_tb.sv
